@@ hw/rtl/smi_pkg.sv @@
package smi_pkg;

    localparam int ANGLE_W    = 16;
    localparam int COUNT_W    = 12;
    localparam int COEF_W     = 32;
    localparam int CHAN_W     = 4;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // interpolation quotient is below |delta| < 2^16
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] US_PER_MS = LEN_W'(1000);

    localparam logic signed [ANGLE_W-1:0] ANGLE_FLOOR_RST   = -16'sd18000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_CEILING_RST = 16'sd18000;
    localparam logic [COUNT_W-1:0]        COUNT_FLOOR_RST   = '0;
    localparam logic [COUNT_W-1:0]        COUNT_CEILING_RST = '1;

    // one half in the 32 fractional bit sum
    localparam logic signed [63:0] ROUND_HALF = 64'sd2147483648;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_DIRECT = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_FLOOR   = 3'd0,
        CFG_ANGLE_CEILING = 3'd1,
        CFG_COUNT_FLOOR   = 3'd2,
        CFG_COUNT_CEILING = 3'd3,
        CFG_COEF_QUAD     = 3'd4,
        CFG_COEF_LIN      = 3'd5,
        CFG_COEF_CONST    = 3'd6,
        CFG_CHANNEL       = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_FINISH = 3'd1,
        OP_REJECT = 3'd2,
        OP_JUMP   = 3'd3,
        OP_START  = 3'd4,
        OP_STOP   = 3'd5,
        OP_DIRECT = 3'd6
    } op_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [ANGLE_W-1:0]  goal_angle;
        logic [MS_W-1:0]            move_ms;
        logic [TIME_W-1:0]          now_us;
        logic [COUNT_W-1:0]         direct_count;
    } in_item_t;

    typedef struct packed {
        logic                       pwm_write;
        logic [CHAN_W-1:0]          pwm_channel;
        logic [COUNT_W-1:0]         pwm_count;
        logic                       moving;
        logic                       status;
        logic signed [ANGLE_W-1:0]  angle_now;
    } out_item_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic mul;
        logic div_step;
        logic interp;
        logic sq;
        logic prod;
        logic sum1;
        logic sum2;
        logic commit;
        logic force_write;
        logic emit;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic in_motion;
        logic range_ok;
        logic ms_zero;
        logic done_now;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/smi_ctrl.sv @@
module smi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  smi_pkg::sts_t sts,
    output smi_pkg::ctl_t ctl,
    output logic          idle
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_MUL    = 11'b000_0000_0100,
        S_DIV    = 11'b000_0000_1000,
        S_INTERP = 11'b000_0001_0000,
        S_SQ     = 11'b000_0010_0000,
        S_PROD   = 11'b000_0100_0000,
        S_SUM1   = 11'b000_1000_0000,
        S_SUM2   = 11'b001_0000_0000,
        S_COMMIT = 11'b010_0000_0000,
        S_RESULT = 11'b100_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [smi_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                           div_last;

    assign div_last = (div_cnt_reg == smi_pkg::DIV_CNT_W'(smi_pkg::DIV_STEPS - 1));
    assign idle     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        div_cnt_next    = div_cnt_reg;
        ctl             = '0;
        ctl.op          = smi_pkg::OP_NONE;
        ctl.force_write = (sts.cmd == smi_pkg::CMD_SET);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    smi_pkg::CMD_TICK:
                    begin
                        priority if (!sts.in_motion)
                        begin
                            state_next = S_RESULT;
                        end
                        else if (sts.done_now)
                        begin
                            ctl.op     = smi_pkg::OP_FINISH;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    smi_pkg::CMD_SET:
                    begin
                        priority if (!sts.range_ok)
                        begin
                            ctl.op     = smi_pkg::OP_REJECT;
                            state_next = S_RESULT;
                        end
                        else if (sts.ms_zero)
                        begin
                            ctl.op     = smi_pkg::OP_JUMP;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            ctl.op     = smi_pkg::OP_START;
                            state_next = S_RESULT;
                        end
                    end
                    smi_pkg::CMD_STOP:
                    begin
                        ctl.op     = sts.in_motion ? smi_pkg::OP_STOP : smi_pkg::OP_NONE;
                        state_next = S_RESULT;
                    end
                    smi_pkg::CMD_DIRECT:
                    begin
                        ctl.op     = smi_pkg::OP_DIRECT;
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_MUL:
            begin
                ctl.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                ctl.interp = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                ctl.sq     = 1'b1;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                ctl.prod   = 1'b1;
                state_next = S_SUM1;
            end
            S_SUM1:
            begin
                ctl.sum1   = 1'b1;
                state_next = S_SUM2;
            end
            S_SUM2:
            begin
                ctl.sum2   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

@@ hw/rtl/smi_dpath.sv @@
module smi_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smi_pkg::ctl_t                      ctl,
    output smi_pkg::sts_t                      sts,
    input  smi_pkg::in_item_t                  in_data,
    input  logic                               cfg_we,
    input  logic [smi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smi_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output smi_pkg::out_item_t                 out_data
);

    localparam int AW = smi_pkg::ANGLE_W;
    localparam int CW = smi_pkg::COUNT_W;
    localparam int LW = smi_pkg::LEN_W;
    localparam int QW = smi_pkg::DIV_STEPS;

    // configuration
    logic signed [AW-1:0]               angle_floor_reg, angle_ceiling_reg;
    logic [CW-1:0]                      count_floor_reg, count_ceiling_reg;
    logic signed [smi_pkg::COEF_W-1:0]  coef_quad_reg, coef_lin_reg, coef_const_reg;
    logic [smi_pkg::CHAN_W-1:0]         channel_reg;

    // move state
    logic signed [AW-1:0]               cur_angle_reg, cur_angle_next;
    logic signed [AW-1:0]               goal_reg, goal_next;
    logic signed [AW-1:0]               from_angle_reg, from_angle_next;
    logic [CW-1:0]                      cur_count_reg, cur_count_next;
    logic                               in_motion_reg, in_motion_next;
    logic [smi_pkg::TIME_W-1:0]         move_start_reg, move_start_next;
    logic [LW-1:0]                      move_len_reg, move_len_next;

    // per item
    smi_pkg::in_item_t                  item_reg;
    logic                               wr_reg, wr_next;
    logic                               status_reg, status_next;
    logic [LW-1:0]                      elapsed_reg;
    logic [smi_pkg::TIME_W-1:0]         elapsed;

    // interpolation
    logic signed [AW:0]                 delta;
    logic                               neg_reg;
    logic [AW-1:0]                      delta_mag;
    logic [AW+LW-1:0]                   prod;
    logic [LW-1:0]                      rem_reg, rem_next;
    logic [QW-1:0]                      quo_reg, quo_next;
    logic [LW:0]                        trial;
    logic signed [AW:0]                 step;
    logic signed [AW:0]                 angle_wide;

    // mapping
    logic signed [31:0]                 xx_full;
    logic [30:0]                        xx_reg;
    logic signed [47:0]                 lin_reg;
    logic signed [63:0]                 quad_reg;
    logic signed [63:0]                 sum1_reg;
    logic signed [63:0]                 sum_reg;
    logic [30:0]                        sum_int;
    logic [CW-1:0]                      upper_cut;
    logic [CW-1:0]                      mapped_count;

    smi_pkg::out_item_t                 out_reg;
    logic                               out_valid_reg;
    logic                               out_free;

    assign elapsed   = item_reg.now_us - move_start_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign sts.cmd       = smi_pkg::cmd_t'(item_reg.cmd);
    assign sts.in_motion = in_motion_reg;
    assign sts.range_ok  = !(item_reg.goal_angle > angle_ceiling_reg ||
                             item_reg.goal_angle < angle_floor_reg);
    assign sts.ms_zero   = (item_reg.move_ms == '0);
    assign sts.done_now  = (elapsed >= smi_pkg::TIME_W'(move_len_reg));
    assign sts.out_free  = out_free;

    // elapsed is below the move length once the multiply runs
    assign delta     = {goal_reg[AW-1], goal_reg} - {from_angle_reg[AW-1], from_angle_reg};
    assign delta_mag = delta[AW] ? AW'(-delta) : delta[AW-1:0];
    assign prod      = (AW+LW)'(delta_mag) * (AW+LW)'(elapsed_reg);

    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign step       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign angle_wide = {from_angle_reg[AW-1], from_angle_reg} + step;

    assign xx_full   = cur_angle_reg * cur_angle_reg;
    assign sum_int   = sum_reg[62:32];
    assign upper_cut = (sum_int > 31'(count_ceiling_reg)) ? count_ceiling_reg
                                                          : sum_int[CW-1:0];

    always_comb
    begin
        priority if (sum_reg[63])
        begin
            mapped_count = count_floor_reg;
        end
        else if (upper_cut < count_floor_reg)
        begin
            mapped_count = count_floor_reg;
        end
        else
        begin
            mapped_count = upper_cut;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctl.mul)
        begin
            rem_next = prod[AW+LW-1:QW];
            quo_next = prod[QW-1:0];
        end
        else if (ctl.div_step)
        begin
            if (trial >= {1'b0, move_len_reg})
            begin
                rem_next = LW'(trial - {1'b0, move_len_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        cur_angle_next  = cur_angle_reg;
        goal_next       = goal_reg;
        from_angle_next = from_angle_reg;
        cur_count_next  = cur_count_reg;
        in_motion_next  = in_motion_reg;
        move_start_next = move_start_reg;
        move_len_next   = move_len_reg;
        wr_next         = wr_reg;
        status_next     = status_reg;
        if (ctl.load)
        begin
            wr_next     = 1'b0;
            status_next = 1'b0;
        end
        unique case (ctl.op)
            smi_pkg::OP_NONE:
            begin
            end
            smi_pkg::OP_FINISH:
            begin
                cur_angle_next = goal_reg;
                in_motion_next = 1'b0;
            end
            smi_pkg::OP_REJECT:
            begin
                status_next = 1'b1;
            end
            smi_pkg::OP_JUMP:
            begin
                goal_next      = item_reg.goal_angle;
                cur_angle_next = item_reg.goal_angle;
                in_motion_next = 1'b0;
            end
            smi_pkg::OP_START:
            begin
                goal_next       = item_reg.goal_angle;
                from_angle_next = cur_angle_reg;
                move_len_next   = LW'(item_reg.move_ms) * smi_pkg::US_PER_MS;
                move_start_next = item_reg.now_us;
                in_motion_next  = 1'b1;
            end
            smi_pkg::OP_STOP:
            begin
                move_start_next = '0;
                in_motion_next  = 1'b0;
                goal_next       = cur_angle_reg;
            end
            smi_pkg::OP_DIRECT:
            begin
                cur_count_next = item_reg.direct_count;
                wr_next        = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (ctl.interp)
        begin
            cur_angle_next = angle_wide[AW-1:0];
        end
        // a jump writes even an unchanged count
        if (ctl.commit && (ctl.force_write || mapped_count != cur_count_reg))
        begin
            cur_count_next = mapped_count;
            wr_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_floor_reg   <= smi_pkg::ANGLE_FLOOR_RST;
            angle_ceiling_reg <= smi_pkg::ANGLE_CEILING_RST;
            count_floor_reg   <= smi_pkg::COUNT_FLOOR_RST;
            count_ceiling_reg <= smi_pkg::COUNT_CEILING_RST;
            coef_quad_reg     <= '0;
            coef_lin_reg      <= '0;
            coef_const_reg    <= '0;
            channel_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (smi_pkg::cfg_idx_t'(cfg_index))
                smi_pkg::CFG_ANGLE_FLOOR:   angle_floor_reg   <= cfg_data[AW-1:0];
                smi_pkg::CFG_ANGLE_CEILING: angle_ceiling_reg <= cfg_data[AW-1:0];
                smi_pkg::CFG_COUNT_FLOOR:   count_floor_reg   <= cfg_data[CW-1:0];
                smi_pkg::CFG_COUNT_CEILING: count_ceiling_reg <= cfg_data[CW-1:0];
                smi_pkg::CFG_COEF_QUAD:     coef_quad_reg     <= cfg_data;
                smi_pkg::CFG_COEF_LIN:      coef_lin_reg      <= cfg_data;
                smi_pkg::CFG_COEF_CONST:    coef_const_reg    <= cfg_data;
                smi_pkg::CFG_CHANNEL:       channel_reg       <= cfg_data[smi_pkg::CHAN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_angle_reg  <= '0;
            goal_reg       <= '0;
            from_angle_reg <= '0;
            cur_count_reg  <= '0;
            in_motion_reg  <= 1'b0;
            move_start_reg <= '0;
            move_len_reg   <= '0;
            wr_reg         <= 1'b0;
            status_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_angle_reg  <= cur_angle_next;
            goal_reg       <= goal_next;
            from_angle_reg <= from_angle_next;
            cur_count_reg  <= cur_count_next;
            in_motion_reg  <= in_motion_next;
            move_start_reg <= move_start_next;
            move_len_reg   <= move_len_next;
            wr_reg         <= wr_next;
            status_reg     <= status_next;
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= in_data;
        end
        elapsed_reg <= elapsed[LW-1:0];
        if (ctl.mul)
        begin
            neg_reg <= delta[AW];
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctl.sq)
        begin
            xx_reg  <= xx_full[30:0];
            lin_reg <= coef_lin_reg * cur_angle_reg;
        end
        if (ctl.prod)
        begin
            quad_reg <= coef_quad_reg * $signed({1'b0, xx_reg});
        end
        if (ctl.sum1)
        begin
            sum1_reg <= quad_reg + $signed({lin_reg, 16'd0});
        end
        if (ctl.sum2)
        begin
            sum_reg <= sum1_reg
                     + $signed({{16{coef_const_reg[31]}}, coef_const_reg, 16'd0})
                     + smi_pkg::ROUND_HALF;
        end
        if (ctl.emit)
        begin
            out_reg.pwm_write   <= wr_reg;
            out_reg.pwm_channel <= channel_reg;
            out_reg.pwm_count   <= cur_count_reg;
            out_reg.moving      <= in_motion_reg;
            out_reg.status      <= status_reg;
            out_reg.angle_now   <= cur_angle_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/servo_move_interpolator.sv @@
// servo move generator: one result beat for every input beat
// in channel: in_valid/in_stall with in_data (cmd, goal_angle, move_ms, now_us,
//   direct_count); a beat is taken when in_valid is high and in_stall low
// out channel: out_valid/out_stall with out_data (pwm_write, pwm_channel,
//   pwm_count, moving, status, angle_now), held steady while out_stall is high
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, write only while no beat is in flight
// one item at a time: stop, direct count, a rejected goal, a timed start and an
//   idle tick go from decode straight to the result step; a jump or a tick
//   that ends a move also runs squaring, two coefficient multiplies, two adds
//   and clamp; a tick inside a move first runs the 16-step restoring divider
//   that forms delta*elapsed/duration
// the result sits in an output register, so the next beat is taken while a
//   finished result still waits; a stalled receiver holds the block in its
//   result step once the following item is done
// reset: asynchronous, active low; idle, angle 0, count 0, default ranges and
//   zero coefficients, channel 0
module servo_move_interpolator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  smi_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output smi_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smi_pkg::CFG_DATA_W-1:0] cfg_data
);

    smi_pkg::ctl_t ctl;
    smi_pkg::sts_t sts;
    logic          idle;

    assign in_stall  = !idle;
    assign cfg_ready = 1'b1;

    smi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .ctl      (ctl),
        .idle     (idle)
    );

    smi_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ hw/rtl/smi_checker.sv @@
module smi_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input smi_pkg::out_item_t             out_data,
    input logic                           cfg_ready
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one item at a time: the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // a rejected goal never writes a count
    a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> !out_data.pwm_write)
        else $error("rejected goal wrote a count");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind servo_move_interpolator smi_checker u_smi_checker (.*);
